### design/abca_pkg.sv
`timescale 1ns / 1ps

package abca_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int PERIOD_W   = 3;
  localparam int SKIP_W     = 9;
  localparam int MID_W      = 12;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int SUM_OUT_W  = 20;
  localparam int CNT_OUT_W  = 9;
  localparam int OFS_W      = 21;
  localparam int AUX_W      = 13;
  localparam int FRAC_BITS  = 8;

  localparam int MAX_FRAMES_DEF = 256;

  localparam logic [PERIOD_W-1:0] PERIOD_RST = 3'd4;
  localparam logic [SKIP_W-1:0]   SKIP_RST   = 9'd111;
  localparam logic [MID_W-1:0]    MID_RST    = 12'd2048;

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MID    = 2'd2;

  typedef struct packed {
    logic frame_take;
    logic mul_go;
    logic div_load;
    logic div_step;
    logic out_load;
  } abca_cmd_t;

  typedef struct packed {
    logic out_full;
  } abca_stat_t;

endpackage

### design/adc_buffer_current_averager_top.sv
`timescale 1ns / 1ps
// ADC buffer current averager.
// Input channel (in_valid/in_ready): one four-channel ADC frame per word, with
// in_buffer_end marking the last frame of a buffer. Frames that do not close a
// buffer are taken one per cycle while the block is idle and give no result.
// The frame that closes a buffer gives one result word on the out_ channel:
// current sum and count, midscale-minus-average offset (8 fractional bits,
// rounded to nearest), first-frame battery and aux values, recharge request
// and empty-count flag.
// A closing frame passes through the multiply state, the divider load state,
// the restoring divider steps (22 + clog2(MAX_FRAMES+1) bits, 31 at the
// default) and the output register load. in_ready stays low until that load,
// so frames of the next buffer are not taken while the last one is still in
// the bit-serial divider.
// The result sits in an output register: once loaded, the next buffer is taken
// while the word waits. If the receiver still stalls when the following buffer
// closes, that result waits in the divider and in_ready stays low.
// cfg_we/cfg_index/cfg_data write the period, skip and midscale registers.
// Synchronous reset (rst_n low) restores register defaults, clears the
// buffer state and countdown and drops any pending result.

module adc_buffer_current_averager_top #(
  parameter int MAX_FRAMES = abca_pkg::MAX_FRAMES_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [abca_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [abca_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [abca_pkg::SAMPLE_W-1:0]          in_aux_a_sample,
  input  logic [abca_pkg::SAMPLE_W-1:0]          in_current_sample,
  input  logic [abca_pkg::SAMPLE_W-1:0]          in_aux_b_sample,
  input  logic [abca_pkg::SAMPLE_W-1:0]          in_battery_sample,
  input  logic                                   in_buffer_end,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [abca_pkg::SUM_OUT_W-1:0]         out_current_sum,
  output logic [abca_pkg::CNT_OUT_W-1:0]         out_counted_frames,
  output logic signed [abca_pkg::OFS_W-1:0]      out_current_offset,
  output logic [abca_pkg::SAMPLE_W-1:0]          out_battery_raw,
  output logic [abca_pkg::AUX_W-1:0]             out_aux_raw,
  output logic                                   out_recharge_request,
  output logic                                   out_empty_count
);

  abca_pkg::abca_cmd_t  cmd;
  abca_pkg::abca_stat_t stat;

  abca_ctrl #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_buffer_end (in_buffer_end),
    .out_ready     (out_ready),
    .in_ready      (in_ready),
    .stat          (stat),
    .cmd           (cmd)
  );

  abca_datapath #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_aux_a_sample      (in_aux_a_sample),
    .in_current_sample    (in_current_sample),
    .in_aux_b_sample      (in_aux_b_sample),
    .in_battery_sample    (in_battery_sample),
    .in_buffer_end        (in_buffer_end),
    .out_ready            (out_ready),
    .cmd                  (cmd),
    .stat                 (stat),
    .out_valid            (out_valid),
    .out_current_sum      (out_current_sum),
    .out_counted_frames   (out_counted_frames),
    .out_current_offset   (out_current_offset),
    .out_battery_raw      (out_battery_raw),
    .out_aux_raw          (out_aux_raw),
    .out_recharge_request (out_recharge_request),
    .out_empty_count      (out_empty_count)
  );

endmodule

### design/abca_ctrl.sv
`timescale 1ns / 1ps

module abca_ctrl #(
  parameter int MAX_FRAMES = abca_pkg::MAX_FRAMES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_buffer_end,
  input  logic                  out_ready,
  output logic                  in_ready,
  input  abca_pkg::abca_stat_t  stat,
  output abca_pkg::abca_cmd_t   cmd
);

  localparam int CNT_W   = $clog2(MAX_FRAMES + 1);
  localparam int SUM_W   = abca_pkg::SAMPLE_W + CNT_W;
  localparam int DVD_W   = SUM_W + abca_pkg::FRAC_BITS + 2;
  localparam int ITER_W  = $clog2(DVD_W);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_LOAD = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [ITER_W-1:0]   iter_r, iter_nxt;

  always_comb begin
    state_nxt = state_r;
    iter_nxt  = iter_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.frame_take = 1'b1;
          if (in_buffer_end) begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        cmd.mul_go = 1'b1;
        state_nxt  = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.div_load = 1'b1;
        iter_nxt     = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        iter_nxt     = iter_r + 1'b1;
        if (iter_r == ITER_W'(DVD_W - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // previous word must be gone or leaving this cycle
        if (!stat.out_full || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      iter_r  <= iter_nxt;
    end
  end

endmodule

### design/abca_datapath.sv
`timescale 1ns / 1ps

module abca_datapath #(
  parameter int MAX_FRAMES = abca_pkg::MAX_FRAMES_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [abca_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [abca_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic [abca_pkg::SAMPLE_W-1:0]          in_aux_a_sample,
  input  logic [abca_pkg::SAMPLE_W-1:0]          in_current_sample,
  input  logic [abca_pkg::SAMPLE_W-1:0]          in_aux_b_sample,
  input  logic [abca_pkg::SAMPLE_W-1:0]          in_battery_sample,
  input  logic                                   in_buffer_end,
  input  logic                                   out_ready,
  input  abca_pkg::abca_cmd_t                    cmd,
  output abca_pkg::abca_stat_t                   stat,
  output logic                                   out_valid,
  output logic [abca_pkg::SUM_OUT_W-1:0]         out_current_sum,
  output logic [abca_pkg::CNT_OUT_W-1:0]         out_counted_frames,
  output logic signed [abca_pkg::OFS_W-1:0]      out_current_offset,
  output logic [abca_pkg::SAMPLE_W-1:0]          out_battery_raw,
  output logic [abca_pkg::AUX_W-1:0]             out_aux_raw,
  output logic                                   out_recharge_request,
  output logic                                   out_empty_count
);

  localparam int CNT_W = $clog2(MAX_FRAMES + 1);
  localparam int SUM_W = abca_pkg::SAMPLE_W + CNT_W;
  localparam int DVD_W = SUM_W + abca_pkg::FRAC_BITS + 2;
  localparam int REM_W = CNT_W + 1;
  localparam int CMP_W = (CNT_W > abca_pkg::SKIP_W) ? CNT_W : abca_pkg::SKIP_W;

  // configuration
  logic [abca_pkg::PERIOD_W-1:0] period_r;
  logic [abca_pkg::SKIP_W-1:0]   skip_r;
  logic [abca_pkg::MID_W-1:0]    mid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= abca_pkg::PERIOD_RST;
      skip_r   <= abca_pkg::SKIP_RST;
      mid_r    <= abca_pkg::MID_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        abca_pkg::REG_PERIOD: period_r <= cfg_data[abca_pkg::PERIOD_W-1:0];
        abca_pkg::REG_SKIP:   skip_r   <= cfg_data[abca_pkg::SKIP_W-1:0];
        abca_pkg::REG_MID:    mid_r    <= cfg_data[abca_pkg::MID_W-1:0];
        default: ;
      endcase
    end
  end

  // per-buffer accumulation
  logic [abca_pkg::PERIOD_W-1:0] cd_r;
  logic [CNT_W-1:0]              fi_r;
  logic [SUM_W-1:0]              sum_r;
  logic [CNT_W-1:0]              cnt_r;
  logic [abca_pkg::SAMPLE_W-1:0] bat_first_r;
  logic [abca_pkg::AUX_W-1:0]    aux_first_r;

  logic [abca_pkg::PERIOD_W-1:0] eff_period;
  logic                          request;
  logic                          skipping;
  logic                          in_range;
  logic                          count_it;
  logic [abca_pkg::SAMPLE_W-1:0] bat_first_nxt;
  logic [abca_pkg::AUX_W-1:0]    aux_first_nxt;
  logic [SUM_W-1:0]              sum_nxt;
  logic [CNT_W-1:0]              cnt_nxt;
  logic [CNT_W-1:0]              fi_nxt;

  always_comb begin
    eff_period = (period_r == '0) ? abca_pkg::PERIOD_W'(1) : period_r;
    request    = (cd_r == '0);
    skipping   = (cd_r != '0) && (cd_r == eff_period - 1'b1);
    in_range   = (fi_r < CNT_W'(MAX_FRAMES));
    count_it   = in_range && !(skipping && (CMP_W'(fi_r) < CMP_W'(skip_r)));
    if (fi_r == '0) begin
      bat_first_nxt = in_battery_sample;
      aux_first_nxt = {1'b0, in_aux_a_sample} + {1'b0, in_aux_b_sample};
    end else begin
      bat_first_nxt = bat_first_r;
      aux_first_nxt = aux_first_r;
    end
    sum_nxt = sum_r + (count_it ? SUM_W'(in_current_sample) : '0);
    cnt_nxt = cnt_r + CNT_W'(count_it);
    fi_nxt  = fi_r + CNT_W'(in_range);
  end

  // snapshot of a closed buffer
  logic [SUM_W-1:0]              sum_s_r;
  logic [CNT_W-1:0]              cnt_s_r;
  logic [abca_pkg::SAMPLE_W-1:0] bat_s_r;
  logic [abca_pkg::AUX_W-1:0]    aux_s_r;
  logic                          req_s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cd_r        <= '0;
      fi_r        <= '0;
      sum_r       <= '0;
      cnt_r       <= '0;
      bat_first_r <= '0;
      aux_first_r <= '0;
    end else if (cmd.frame_take) begin
      bat_first_r <= bat_first_nxt;
      aux_first_r <= aux_first_nxt;
      if (in_buffer_end) begin
        cd_r  <= (request ? eff_period : cd_r) - 1'b1;
        fi_r  <= '0;
        sum_r <= '0;
        cnt_r <= '0;
      end else begin
        fi_r  <= fi_nxt;
        sum_r <= sum_nxt;
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.frame_take && in_buffer_end) begin
      sum_s_r <= sum_nxt;
      cnt_s_r <= cnt_nxt;
      bat_s_r <= bat_first_nxt;
      aux_s_r <= aux_first_nxt;
      req_s_r <= request;
    end
  end

  // offset: round((mid*cnt - sum) * 256 / cnt), restoring divider one bit a cycle
  logic [SUM_W-1:0] prod_r;
  logic [SUM_W:0]   diff;
  logic [SUM_W:0]   mag_full;
  logic             neg;
  logic [DVD_W-1:0] dvd_init;
  logic [DVD_W-1:0] dvd_r;
  logic [REM_W-1:0] rem_r;
  logic             neg_r;
  logic [REM_W:0]   rem_sh;
  logic [REM_W:0]   divisor;
  logic [REM_W:0]   rem_sub;
  logic             q_bit;

  always_comb begin
    diff     = {1'b0, prod_r} - {1'b0, sum_s_r};
    neg      = diff[SUM_W];
    mag_full = neg ? (~diff + 1'b1) : diff;
    dvd_init = DVD_W'({mag_full[SUM_W-1:0], {(abca_pkg::FRAC_BITS + 1){1'b0}}})
             + DVD_W'(cnt_s_r);
    divisor  = {1'b0, cnt_s_r, 1'b0};
    rem_sh   = {rem_r, dvd_r[DVD_W-1]};
    rem_sub  = rem_sh - divisor;
    q_bit    = (rem_sh >= divisor);
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      prod_r <= SUM_W'(mid_r) * SUM_W'(cnt_s_r);
    end
    if (cmd.div_load) begin
      dvd_r <= dvd_init;
      rem_r <= '0;
      neg_r <= neg;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[DVD_W-2:0], q_bit};
      rem_r <= q_bit ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
    end
  end

  // output register
  logic                              out_valid_r;
  logic [abca_pkg::SUM_OUT_W-1:0]    o_sum_r;
  logic [abca_pkg::CNT_OUT_W-1:0]    o_cnt_r;
  logic [abca_pkg::OFS_W-1:0]        o_ofs_r;
  logic [abca_pkg::SAMPLE_W-1:0]     o_bat_r;
  logic [abca_pkg::AUX_W-1:0]        o_aux_r;
  logic                              o_req_r;
  logic                              o_empty_r;

  logic [SUM_W+abca_pkg::SUM_OUT_W-1:0] sum_wide;
  logic [CNT_W+abca_pkg::CNT_OUT_W-1:0] cnt_wide;
  logic [abca_pkg::OFS_W-1:0]           quo;
  logic [abca_pkg::OFS_W-1:0]           ofs_nxt;
  logic                                 empty;

  always_comb begin
    sum_wide = {{abca_pkg::SUM_OUT_W{1'b0}}, sum_s_r};
    cnt_wide = {{abca_pkg::CNT_OUT_W{1'b0}}, cnt_s_r};
    quo      = dvd_r[abca_pkg::OFS_W-1:0];
    empty    = (cnt_s_r == '0);
    if (empty) begin
      ofs_nxt = '0;
    end else if (neg_r) begin
      ofs_nxt = '0 - quo;
    end else begin
      ofs_nxt = quo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_sum_r   <= sum_wide[abca_pkg::SUM_OUT_W-1:0];
      o_cnt_r   <= cnt_wide[abca_pkg::CNT_OUT_W-1:0];
      o_ofs_r   <= ofs_nxt;
      o_bat_r   <= bat_s_r;
      o_aux_r   <= aux_s_r;
      o_req_r   <= req_s_r;
      o_empty_r <= empty;
    end
  end

  assign stat.out_full         = out_valid_r;
  assign out_valid             = out_valid_r;
  assign out_current_sum       = o_sum_r;
  assign out_counted_frames    = o_cnt_r;
  assign out_current_offset    = $signed(o_ofs_r);
  assign out_battery_raw       = o_bat_r;
  assign out_aux_raw           = o_aux_r;
  assign out_recharge_request  = o_req_r;
  assign out_empty_count       = o_empty_r;

endmodule

### design/abca_checker.sv
`timescale 1ns / 1ps

module abca_checker (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   in_valid,
  input logic                                   in_ready,
  input logic                                   in_buffer_end,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input logic [abca_pkg::SUM_OUT_W-1:0]         out_current_sum,
  input logic signed [abca_pkg::OFS_W-1:0]      out_current_offset,
  input logic                                   out_empty_count
);

  // a closing frame starts the offset computation: no frame can follow at once
  a_close_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_buffer_end) |=> !in_ready)
    else $error("frame taken right after a buffer end");

  a_empty_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_empty_count) |-> (out_current_offset == '0))
    else $error("empty buffer with nonzero offset");

  a_sum_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_current_sum != '0)) |-> !out_empty_count)
    else $error("nonzero sum flagged as empty");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_current_sum) && $stable(out_current_offset)))
    else $error("result word changed while stalled");

endmodule

bind adc_buffer_current_averager_top abca_checker u_abca_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .in_buffer_end      (in_buffer_end),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_current_sum    (out_current_sum),
  .out_current_offset (out_current_offset),
  .out_empty_count    (out_empty_count)
);
